### design/pfr_pkg.sv
package pfr_pkg;

  localparam int unsigned COLUMN_GROUPS = 200;
  localparam int unsigned BLOCK_ROWS    = 75;
  localparam int unsigned STORE_BYTES   = COLUMN_GROUPS * BLOCK_ROWS;
  localparam int unsigned LOGICAL_ROWS  = 4 * BLOCK_ROWS;
  localparam int unsigned LOGICAL_COLS  = 2 * COLUMN_GROUPS;
  localparam int unsigned ADDR_W        = $clog2(STORE_BYTES);
  localparam int unsigned GROUP_W       = $clog2(COLUMN_GROUPS);
  localparam int unsigned ROWIDX_W      = $clog2(BLOCK_ROWS);
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam logic [15:0] MASK_RESET = 16'd127;

  typedef enum logic [1:0] {
    REQ_WRITE   = 2'd0,
    REQ_EOF     = 2'd1,
    REQ_READ    = 2'd2,
    REQ_OUTCOME = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_ACK   = 3'd0,
    ST_SKIP  = 3'd1,
    ST_FULL  = 3'd2,
    ST_RANGE = 3'd3,
    ST_READ  = 3'd4,
    ST_FAIL  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    PEND_NONE    = 2'd0,
    PEND_PARTIAL = 2'd1,
    PEND_FULL    = 2'd2
  } pend_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [8:0]  pixel_row;
    logic [5:0]  byte_column;
    logic [7:0]  pixel_bits;
    logic [13:0] native_index;
    logic        transfer_ok;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] first_group;
    logic [7:0] last_group;
    logic [7:0] read_byte;
  } rsp_t;

  // classified command handed from front to back
  typedef struct packed {
    req_e              kind;
    logic              valid_row;
    logic [ADDR_W-1:0] base;
    logic [1:0]        quad;
    logic [7:0]        bits;
    logic              idx_ok;
    logic [ADDR_W-1:0] idx;
    logic              ok;
  } cmd_t;

endpackage

### design/panel_frame_repack_dirty_update_core.sv
// end of frame compares one native and one sent byte per cycle
// throughput: one command at a time through the back end, a two-entry queue
// in front; the receiver cannot stall, results are strobed for one cycle
// reset: asynchronous active low, then an init pass fills both stores white
module panel_frame_repack_dirty_update_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  pfr_pkg::req_t req_i,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i,
  output logic          done,
  output pfr_pkg::rsp_t rsp_o
);
  import pfr_pkg::*;

  logic push, full, pop, empty;
  cmd_t cmd_in, cmd_out;

  pfr_front u_front (
    .start_i(start), .busy_o(busy), .req_i, .push_o(push), .cmd_o(cmd_in), .full_i(full)
  );
  pfr_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(cmd_in), .full_o(full),
    .pop_i(pop), .empty_o(empty), .data_o(cmd_out)
  );
  pfr_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .cmd_i(cmd_out), .pop_o(pop),
    .mask_we_i(cfg_we_i), .mask_wdata_i(cfg_wdata_i), .done_o(done), .rsp_o
  );
endmodule

### design/pfr_ram.sv
module pfr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

### design/pfr_front.sv
module pfr_front (
  input  logic          start_i,
  output logic          busy_o,
  input  pfr_pkg::req_t req_i,
  output logic          push_o,
  output pfr_pkg::cmd_t cmd_o,
  input  logic          full_i
);
  import pfr_pkg::*;

  logic [8:0]  inv;
  logic [13:0] base_w;

  assign busy_o = full_i;
  assign push_o = start_i && !full_i;

  always_comb begin
    inv    = 9'(LOGICAL_ROWS - 1) - req_i.pixel_row;
    base_w = 14'(req_i.byte_column) * 14'(4 * BLOCK_ROWS) + 14'(inv[8:2]);
    cmd_o.kind      = req_e'(req_i.req_type);
    cmd_o.valid_row = (req_i.pixel_row < 9'(LOGICAL_ROWS)) &&
                      (req_i.byte_column < 6'(LOGICAL_COLS / 8));
    cmd_o.base      = ADDR_W'(base_w);
    cmd_o.quad      = inv[1:0];
    cmd_o.bits      = req_i.pixel_bits;
    cmd_o.idx_ok    = req_i.native_index < 14'(STORE_BYTES);
    cmd_o.idx       = ADDR_W'(req_i.native_index);
    cmd_o.ok        = req_i.transfer_ok;
  end
endmodule

### design/pfr_queue.sv
module pfr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pfr_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output pfr_pkg::cmd_t data_o
);
  import pfr_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  cmd_t          slot_q [QUEUE_DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0]   cnt_q;

  assign full_o  = cnt_q == (PW+1)'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = slot_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= (rp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
      end
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end
endmodule

### design/pfr_back.sv
module pfr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  pfr_pkg::cmd_t cmd_i,
  output logic          pop_o,
  input  logic          mask_we_i,
  input  logic [15:0]   mask_wdata_i,
  output logic          done_o,
  output pfr_pkg::rsp_t rsp_o
);
  import pfr_pkg::*;

  typedef enum logic [9:0] {
    S_INIT  = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_WRD   = 10'b0000000100,
    S_WRW   = 10'b0000001000,
    S_RDW   = 10'b0000010000,
    S_CMPR  = 10'b0000100000,
    S_CMPW  = 10'b0001000000,
    S_COPYR = 10'b0010000000,
    S_COPYW = 10'b0100000000,
    S_RESP  = 10'b1000000000
  } state_e;

  state_e              st_q, st_d;
  cmd_t                cur_q;
  logic [ADDR_W-1:0]   ptr_q, ptr_d;
  logic [1:0]          k_q, k_d;
  logic [ROWIDX_W-1:0] r_q, r_d;
  logic [GROUP_W-1:0]  g_q, g_d;
  logic                dirty_q, dirty_d, found_q, found_d;
  logic [GROUP_W-1:0]  g1_q, g1_d, g2_q, g2_d;
  logic [15:0]         cnt_q, cnt_d, mask_q;
  pend_e               pend_q, pend_d;
  rsp_t                rsp_q, rsp_d;
  logic                done_q, done_d;

  logic              nwe, swe;
  logic [ADDR_W-1:0] nwa, nra, sra;
  logic [7:0]        nwd, nrd, srd, swd;
  logic [7:0]        upd;
  logic              last_addr;
  logic [15:0]       cinc;

  pfr_ram #(.Width(8), .Depth(STORE_BYTES)) u_native (
    .clk_i, .we_i(nwe), .waddr_i(nwa), .wdata_i(nwd), .raddr_i(nra), .rdata_o(nrd)
  );
  pfr_ram #(.Width(8), .Depth(STORE_BYTES)) u_sent (
    .clk_i, .we_i(swe), .waddr_i(ptr_q), .wdata_i(swd), .raddr_i(sra), .rdata_o(srd)
  );

  assign last_addr = ptr_q == ADDR_W'(STORE_BYTES - 1);
  assign pop_o     = (st_q == S_IDLE) && !empty_i;
  assign done_o    = done_q;
  assign rsp_o     = rsp_q;
  assign cinc      = cnt_q + 16'd1;
  assign swd       = (st_q == S_INIT) ? 8'hFF : nrd;

  // two pixels of logical x = 8*col + 2k, 2k+1 land in one native byte
  always_comb begin
    logic [3:0] x0;
    upd = nrd;
    for (int j = 0; j < 2; j++) begin
      x0 = 4'({k_q, 1'b0}) + 4'(j);
      upd[3'd7 - 3'({cur_q.quad, 1'b0} | 3'(j))] = !cur_q.bits[3'd7 - 3'(x0)];
    end
  end

  always_comb begin
    st_d = st_q; ptr_d = ptr_q; k_d = k_q; r_d = r_q; g_d = g_q;
    dirty_d = dirty_q; found_d = found_q; g1_d = g1_q; g2_d = g2_q;
    cnt_d = cnt_q; pend_d = pend_q; rsp_d = rsp_q; done_d = 1'b0;
    nwe = 1'b0; swe = 1'b0; nwa = ptr_q; nwd = upd; nra = ptr_q; sra = ptr_q;
    case (st_q)
      S_INIT: begin
        nwe = 1'b1; nwd = 8'hFF; swe = 1'b1;
        if (last_addr) st_d = S_IDLE;
        else ptr_d = ptr_q + 1'b1;
      end
      S_IDLE: begin
        rsp_d = '0;
        if (!empty_i) begin
          ptr_d = '0; k_d = '0; r_d = '0; g_d = '0;
          dirty_d = 1'b0; found_d = 1'b0; g1_d = '0; g2_d = '0;
          case (cmd_i.kind)
            REQ_WRITE: begin
              if (cmd_i.valid_row) begin
                ptr_d = cmd_i.base; nra = cmd_i.base; st_d = S_WRD;
              end else st_d = S_RESP;
            end
            REQ_READ: begin
              nra = cmd_i.idx; st_d = S_RDW;
            end
            REQ_EOF: begin
              nra = '0; sra = '0; st_d = S_CMPR;
            end
            REQ_OUTCOME: begin
              if (pend_q == PEND_NONE) st_d = S_RESP;
              else if (cmd_i.ok) begin
                nra = '0; pend_d = PEND_NONE; st_d = S_COPYR;
              end else if (pend_q == PEND_PARTIAL) begin
                pend_d = PEND_FULL; rsp_d.status = ST_FULL;
                rsp_d.last_group = 8'(COLUMN_GROUPS - 1); st_d = S_RESP;
              end else begin
                pend_d = PEND_NONE; rsp_d.status = ST_FAIL; st_d = S_RESP;
              end
            end
            default: st_d = S_RESP;
          endcase
        end
      end
      S_WRD: st_d = S_WRW;
      S_WRW: begin
        nwe = 1'b1;
        if (k_q == 2'd3) st_d = S_RESP;
        else begin
          k_d = k_q + 1'b1;
          ptr_d = ptr_q + ADDR_W'(BLOCK_ROWS);
          nra = ptr_q + ADDR_W'(BLOCK_ROWS);
          st_d = S_WRD;
        end
      end
      S_RDW: begin
        rsp_d.status = ST_READ;
        rsp_d.read_byte = cur_q.idx_ok ? nrd : 8'd0;
        st_d = S_RESP;
      end
      S_CMPR: begin
        ptr_d = ptr_q + 1'b1;
        st_d = S_CMPW;
      end
      S_CMPW: begin
        // data for ptr_q-1 is on the ram outputs
        dirty_d = dirty_q || (nrd != srd);
        if (r_q == ROWIDX_W'(BLOCK_ROWS - 1)) begin
          r_d = '0;
          if (dirty_q || (nrd != srd)) begin
            if (!found_q) g1_d = g_q;
            found_d = 1'b1; g2_d = g_q;
          end
          dirty_d = 1'b0;
          if (g_q == GROUP_W'(COLUMN_GROUPS - 1)) begin
            st_d = S_RESP;
            if (!(found_q || dirty_q || (nrd != srd))) begin
              pend_d = PEND_NONE; rsp_d.status = ST_SKIP;
            end else begin
              cnt_d = cinc;
              if ((cinc & mask_q) == 16'd0) begin
                pend_d = PEND_FULL; rsp_d.status = ST_FULL;
                rsp_d.last_group = 8'(COLUMN_GROUPS - 1);
              end else begin
                pend_d = PEND_PARTIAL; rsp_d.status = ST_RANGE;
                rsp_d.first_group = 8'(found_q ? g1_q : g_q);
                rsp_d.last_group  = 8'((dirty_q || (nrd != srd)) ? g_q : g2_q);
              end
            end
          end else g_d = g_q + 1'b1;
        end else r_d = r_q + 1'b1;
        if (st_d == S_CMPW) ptr_d = ptr_q + 1'b1;
      end
      S_COPYR: st_d = S_COPYW;
      S_COPYW: begin
        swe = 1'b1;
        if (last_addr) st_d = S_RESP;
        else begin
          ptr_d = ptr_q + 1'b1; nra = ptr_q + 1'b1; st_d = S_COPYW;
        end
      end
      S_RESP: begin
        done_d = 1'b1; st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_INIT; ptr_q <= '0; k_q <= '0; r_q <= '0; g_q <= '0;
      dirty_q <= 1'b0; found_q <= 1'b0; g1_q <= '0; g2_q <= '0;
      cnt_q <= '0; pend_q <= PEND_NONE; rsp_q <= '0; done_q <= 1'b0;
      mask_q <= MASK_RESET;
    end else begin
      st_q <= st_d; ptr_q <= ptr_d; k_q <= k_d; r_q <= r_d; g_q <= g_d;
      dirty_q <= dirty_d; found_q <= found_d; g1_q <= g1_d; g2_q <= g2_d;
      cnt_q <= cnt_d; pend_q <= pend_d; rsp_q <= rsp_d; done_q <= done_d;
      if (mask_we_i) mask_q <= mask_wdata_i;
    end
  end
endmodule

### design/pfr_checker.sv
module pfr_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          busy,
  input logic          done,
  input pfr_pkg::rsp_t rsp_o
);
  import pfr_pkg::*;

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> rsp_o.status <= ST_FAIL) else $error("bad status");
  a_read_groups: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done && rsp_o.status == ST_READ |-> rsp_o.first_group == 8'd0 && rsp_o.last_group == 8'd0)
    else $error("read with groups");
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done && rsp_o.status == ST_RANGE |-> rsp_o.first_group <= rsp_o.last_group)
    else $error("range order");
  a_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> !done) else $error("done held");
  a_busy_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown(busy)) else $error("busy unknown");
endmodule

bind panel_frame_repack_dirty_update_core pfr_checker u_checker (
  .clk_i, .rst_ni, .busy, .done, .rsp_o
);
